### rtl/core/si2dec_pkg.sv
package si2dec_pkg;

    // Input word and decimal digit counts
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(VAL_W);
    localparam int NDIG      = 10;
    localparam int NDIG_W    = $clog2(NDIG + 1);
    localparam int BCD_W     = 4 * NDIG;

    // Text buffer: at most LINE_BUFFER_SIZE - 1 digits fit
    localparam int LINE_BUFFER_SIZE = 256;
    localparam int BUF_CMP_W        = 13;
    localparam logic [BUF_CMP_W-1:0] MAX_DIGITS = BUF_CMP_W'(LINE_BUFFER_SIZE - 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NONE   = 8'h00;

    // Status from the binary-to-BCD converter
    typedef struct packed {
        logic busy;
        logic done;
    } t_dd_stat;

endpackage

### rtl/core/si2dec_dabble.sv
module si2dec_dabble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [si2dec_pkg::VAL_W-1:0]  i_mag,
    output si2dec_pkg::t_dd_stat          o_stat,
    output logic [si2dec_pkg::BCD_W-1:0]  o_bcd
);
    import si2dec_pkg::*;

    logic [VAL_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [BCD_W-1:0] n_adj;

    // Shift-add-3: each digit of 5 or more gets +3 before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_mag;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {n_adj[BCD_W-2:0], r_bin[VAL_W-1]};
                r_bin <= {r_bin[VAL_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

    a_done_after_last_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == CNT_W'(VAL_W - 1) |=> r_done && !r_busy)
        else $error("converter did not finish after the last shift");

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_value[31:0] signed
// out      output     o_valid / i_stall  o_char_code[7:0], o_is_last, o_overflow
//
// A request is accepted, passes through the bit-serial binary-to-BCD shifter,
// has its digits loaded and its leading zero digits dropped, then goes out one
// byte per cycle while i_stall is low.
// Reset is synchronous, active low; no clearing pass.
// o_stall is high while a value is in work; the next request is taken while
// the last byte still waits in the output register.
module signed_int_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [si2dec_pkg::VAL_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_char_code,
    output logic                          o_is_last,
    output logic                          o_overflow
);
    import si2dec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic              r_neg;
    logic              r_sign_pend;
    logic              r_ovf_pend;
    logic [BCD_W-1:0]  r_digits;
    logic [NDIG_W-1:0] r_ndig;
    logic              r_out_valid;
    logic [7:0]        r_char;
    logic              r_last;
    logic              r_ovf;

    logic              n_start;
    logic [VAL_W-1:0]  n_mag;
    logic [3:0]        n_top;
    logic              n_take;
    t_dd_stat          dd_stat;
    logic [BCD_W-1:0]  dd_bcd;

    assign n_start = (r_state == S_IDLE) && i_valid;
    assign n_mag   = i_value[VAL_W-1] ? (VAL_W'(0) - i_value) : i_value;
    assign n_top   = r_digits[BCD_W-1 -: 4];
    assign n_take  = !r_out_valid || !i_stall;

    si2dec_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_mag   (n_mag),
        .o_stat  (dd_stat),
        .o_bcd   (dd_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
            r_ovf_pend  <= 1'b0;
            r_ndig      <= '0;
        end else begin
            // in S_EMIT the output register is reloaded whenever it drains
            if (r_out_valid && !i_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg   <= i_value[VAL_W-1];
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (dd_stat.done) begin
                        r_digits <= dd_bcd;
                        r_ndig   <= NDIG_W'(NDIG);
                        r_state  <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    // drop leading zeros, keeping at least one digit
                    if (r_ndig != NDIG_W'(1) && n_top == 4'd0) begin
                        r_digits <= {r_digits[BCD_W-5:0], 4'd0};
                        r_ndig   <= r_ndig - 1'b1;
                    end else begin
                        r_ovf_pend  <= BUF_CMP_W'(r_ndig) > MAX_DIGITS;
                        r_sign_pend <= r_neg;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_take) begin
                        r_out_valid <= 1'b1;
                        if (r_ovf_pend) begin
                            r_char     <= CHAR_NONE;
                            r_last     <= 1'b1;
                            r_ovf      <= 1'b1;
                            r_ovf_pend <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (r_sign_pend) begin
                            r_char      <= ASCII_MINUS;
                            r_last      <= 1'b0;
                            r_ovf       <= 1'b0;
                            r_sign_pend <= 1'b0;
                        end else begin
                            r_char   <= ASCII_ZERO + {4'd0, n_top};
                            r_last   <= (r_ndig == NDIG_W'(1));
                            r_ovf    <= 1'b0;
                            r_digits <= {r_digits[BCD_W-5:0], 4'd0};
                            r_ndig   <= r_ndig - 1'b1;
                            if (r_ndig == NDIG_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;
    assign o_overflow  = r_ovf;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state == S_CONV && dd_stat.busy)
        else $error("accepted request did not start conversion");

    a_done_only_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dd_stat.done |-> r_state == S_CONV)
        else $error("converter finished outside conversion");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && !r_ovf_pend |-> r_ndig != '0)
        else $error("emitting with no digits left");

    a_ovf_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_is_last && o_char_code == CHAR_NONE)
        else $error("overflow byte malformed");

endmodule
